// File: hdl/assert_macros.svh
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define AST_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is active
`define AST_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: hdl/lste_pkg.sv
// shared types and constants of the lzw string table engine
package lste_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int SLOT_W        = 12;
    localparam int STEP_W        = 13;
    localparam int PRED_W        = 16;
    localparam int FOLL_W        = 8;

    localparam logic [SLOT_W-1:0] SLOT_MASK  = 12'h0FFF;
    localparam logic [SLOT_W-1:0] PROBE_GAP  = 12'd101;
    localparam logic [PRED_W-1:0] HASH_OR    = 16'h0800;
    localparam logic [PRED_W-1:0] ROOT_PRED  = 16'hFFFF;
    localparam int                HASH_LSB   = 6;
    localparam logic [FOLL_W-1:0] ROOT_LAST  = 8'hFF;

    typedef enum logic [1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_INIT   = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    typedef struct packed {
        logic              used;
        logic [SLOT_W-1:0] next;
        logic [PRED_W-1:0] pred;
        logic [FOLL_W-1:0] foll;
    } t_entry;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_HOME,
        S_LOOKUP,
        S_INS_HOME,
        S_TAIL,
        S_PROBE,
        S_FILL
    } t_state;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLEAR,
        WR_HOME,
        WR_LINK,
        WR_CAND
    } t_wr;

    typedef enum logic [2:0] {
        RD_CUR,
        RD_HOME,
        RD_NEXT,
        RD_GAP,
        RD_STEP
    } t_rd;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_CUR,
        RES_CAND,
        RES_FULL
    } t_res;

    typedef struct packed {
        logic load;
        logic root_ld;
        logic root_inc;
        logic hash;
        logic set_home;
        logic walk;
        logic probe_start;
        logic probe_next;
        logic clr_inc;
        logic finish;
        t_res res;
        t_wr  wr;
        t_rd  rd;
    } t_cmd;

    typedef struct packed {
        t_func in_func;
        t_func func;
        logic  init_mode;
        logic  used;
        logic  match;
        logic  next_zero;
        logic  step_last;
        logic  tail_last;
        logic  clr_last;
        logic  root_last;
    } t_sts;

endpackage

// File: hdl/lzw_string_table_engine.sv
// top level of the lzw string table engine
// Holds a 4096-entry LZW string table (used, 12-bit link, 16-bit predecessor,
// 8-bit follower) in one single-port-write memory with a registered read.
// An item is taken when start is high and busy is low; its result appears
// on o_slot, o_found and o_table_full for one cycle with o_strobe, and must
// be taken then since the receiver cannot stall. Busy stays high while an
// item is worked on. The memory gives one read per cycle: a lookup hashes
// the key, reads the home slot and then follows the chain one entry per
// read; an insert into a free home slot writes it there; an insert behind
// a chain walks the links to the tail, probes for a free slot and links
// it in; and the unused function code returns all zeros in the cycle after
// the transfer. Init sweeps all 4096 entries, one per cycle, then seeds the
// 256 roots through the insert path. After reset the same clearing pass
// runs with busy high before the first item is taken.
module lzw_string_table_engine import lste_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_func,
    input  logic [PRED_W-1:0] i_prefix_code,
    input  logic [FOLL_W-1:0] i_next_byte,
    output logic              o_strobe,
    output logic [SLOT_W-1:0] o_slot,
    output logic              o_found,
    output logic              o_table_full
);

    t_cmd w_cmd;
    t_sts w_sts;

    lste_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    lste_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_func        (i_func),
        .i_prefix_code (i_prefix_code),
        .i_next_byte   (i_next_byte),
        .o_sts         (w_sts),
        .o_slot        (o_slot),
        .o_found       (o_found),
        .o_table_full  (o_table_full),
        .o_strobe      (o_strobe)
    );

endmodule

// File: hdl/lste_ctrl.sv
// sequencer of the lzw string table engine
module lste_ctrl import lste_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy
);

    t_state r_state, n_state;
    t_state w_ins_end;

    // where an insert goes when it is done: next root while seeding, else idle
    assign w_ins_end = (i_sts.init_mode && !i_sts.root_last) ? S_HASH : S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = i_sts.init_mode ? S_HASH : S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    unique case (i_sts.in_func)
                        FUNC_INIT:                n_state = S_CLEAR;
                        FUNC_LOOKUP, FUNC_INSERT: n_state = S_HASH;
                        default:                  n_state = S_IDLE;
                    endcase
                end
            end
            S_HASH: n_state = S_HOME;
            S_HOME: begin
                n_state = (i_sts.func == FUNC_LOOKUP) ? S_LOOKUP : S_INS_HOME;
            end
            S_LOOKUP: begin
                if (i_sts.match || i_sts.next_zero || i_sts.step_last) begin
                    n_state = S_IDLE;
                end
            end
            S_INS_HOME: begin
                if (!i_sts.used) begin
                    n_state = w_ins_end;
                end else if (i_sts.next_zero) begin
                    n_state = S_PROBE;
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                if (i_sts.next_zero || i_sts.tail_last) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (!i_sts.used) begin
                    n_state = S_FILL;
                end else if (i_sts.step_last) begin
                    n_state = w_ins_end;
                end
            end
            S_FILL: n_state = w_ins_end;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        t_res v_ins_res;
        o_cmd.load        = 1'b0;
        o_cmd.root_ld     = 1'b0;
        o_cmd.root_inc    = 1'b0;
        o_cmd.hash        = 1'b0;
        o_cmd.set_home    = 1'b0;
        o_cmd.walk        = 1'b0;
        o_cmd.probe_start = 1'b0;
        o_cmd.probe_next  = 1'b0;
        o_cmd.clr_inc     = 1'b0;
        o_cmd.finish      = 1'b0;
        o_cmd.res         = RES_NONE;
        o_cmd.wr          = WR_NONE;
        o_cmd.rd          = RD_CUR;
        v_ins_res         = RES_NONE;
        busy              = (r_state != S_IDLE);

        unique case (r_state)
            S_CLEAR: begin
                o_cmd.wr      = WR_CLEAR;
                o_cmd.clr_inc = 1'b1;
                if (i_sts.clr_last && i_sts.init_mode) begin
                    o_cmd.root_ld = 1'b1;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.in_func == FUNC_NOP) begin
                        o_cmd.finish = 1'b1;
                    end
                end
            end
            S_HASH: o_cmd.hash = 1'b1;
            S_HOME: begin
                o_cmd.set_home = 1'b1;
                o_cmd.rd       = RD_HOME;
            end
            S_LOOKUP: begin
                if (i_sts.match) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.res    = RES_CUR;
                end else if (i_sts.next_zero || i_sts.step_last) begin
                    o_cmd.finish = 1'b1;
                end else begin
                    o_cmd.walk = 1'b1;
                    o_cmd.rd   = RD_NEXT;
                end
            end
            S_INS_HOME, S_TAIL: begin
                if (r_state == S_INS_HOME && !i_sts.used) begin
                    o_cmd.wr  = WR_HOME;
                    v_ins_res = RES_CUR;
                end else if (i_sts.next_zero || i_sts.tail_last) begin
                    o_cmd.probe_start = 1'b1;
                    o_cmd.rd          = RD_GAP;
                end else begin
                    o_cmd.walk = 1'b1;
                    o_cmd.rd   = RD_NEXT;
                end
            end
            S_PROBE: begin
                if (!i_sts.used) begin
                    o_cmd.wr = WR_LINK;
                end else if (i_sts.step_last) begin
                    v_ins_res = RES_FULL;
                end else begin
                    o_cmd.probe_next = 1'b1;
                    o_cmd.rd         = RD_STEP;
                end
            end
            S_FILL: begin
                o_cmd.wr  = WR_CAND;
                v_ins_res = RES_CAND;
            end
            default: ;
        endcase

        // end of one insert: seeding moves silently to the next root, or ends
        if (v_ins_res != RES_NONE) begin
            if (i_sts.init_mode) begin
                if (i_sts.root_last) begin
                    o_cmd.finish = 1'b1;
                end else begin
                    o_cmd.root_inc = 1'b1;
                end
            end else begin
                o_cmd.finish = 1'b1;
                o_cmd.res    = v_ins_res;
            end
        end
    end

endmodule

// File: hdl/lste_dp.sv
// datapath of the lzw string table engine: key, hash, pointers and the table memory
module lste_dp import lste_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [1:0]        i_func,
    input  logic [PRED_W-1:0] i_prefix_code,
    input  logic [FOLL_W-1:0] i_next_byte,
    output t_sts              o_sts,
    output logic [SLOT_W-1:0] o_slot,
    output logic              o_found,
    output logic              o_table_full,
    output logic              o_strobe
);

    t_entry r_mem [TABLE_ENTRIES];

    t_func             r_func;
    logic [PRED_W-1:0] r_kpred;
    logic [FOLL_W-1:0] r_kfoll;
    logic [31:0]       r_sq;
    logic [SLOT_W-1:0] r_cur;
    logic [SLOT_W-1:0] r_tail;
    logic [SLOT_W-1:0] r_cand;
    t_entry            r_tail_ent;
    logic [STEP_W-1:0] r_steps;
    logic [SLOT_W-1:0] r_clr;
    logic [FOLL_W-1:0] r_root;
    t_entry            r_rd;
    logic              r_strobe;
    logic [SLOT_W-1:0] r_slot;
    logic              r_found;
    logic              r_full;

    logic [PRED_W-1:0] w_hs;
    logic [SLOT_W-1:0] w_home;
    logic [SLOT_W-1:0] w_raddr;
    logic [SLOT_W-1:0] w_waddr;
    t_entry            w_wdata;
    logic              w_we;

    // mid-square hash: sum wraps to 16 bits, bit 11 forced on
    assign w_hs   = (r_kpred + {{(PRED_W-FOLL_W){1'b0}}, r_kfoll}) | HASH_OR;
    assign w_home = r_sq[HASH_LSB +: SLOT_W];

    always_comb begin
        case (i_cmd.rd)
            RD_HOME: w_raddr = w_home;
            RD_NEXT: w_raddr = r_rd.next;
            RD_GAP:  w_raddr = r_cur + PROBE_GAP;
            RD_STEP: w_raddr = r_cand + 1'b1;
            default: w_raddr = r_cur;
        endcase
    end

    always_comb begin
        w_we    = 1'b1;
        w_waddr = r_cur;
        w_wdata = '0;
        case (i_cmd.wr)
            WR_CLEAR: w_waddr = r_clr;
            WR_HOME: begin
                w_waddr = r_cur;
                w_wdata = '{used: 1'b1, next: '0, pred: r_kpred, foll: r_kfoll};
            end
            WR_LINK: begin
                w_waddr      = r_tail;
                w_wdata      = r_tail_ent;
                w_wdata.next = r_cand;
            end
            WR_CAND: begin
                w_waddr = r_cand;
                w_wdata = '{used: 1'b1, next: '0, pred: r_kpred, foll: r_kfoll};
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_func   <= FUNC_LOOKUP;
            r_clr    <= '0;
            r_root   <= '0;
            r_steps  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.finish;
            if (i_cmd.load) begin
                r_func <= t_func'(i_func);
            end
            if (i_cmd.clr_inc) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.root_ld) begin
                r_root <= '0;
            end else if (i_cmd.root_inc) begin
                r_root <= r_root + 1'b1;
            end
            if (i_cmd.hash || i_cmd.probe_start) begin
                r_steps <= '0;
            end else if (i_cmd.walk || i_cmd.probe_next) begin
                r_steps <= r_steps + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kpred <= i_prefix_code;
            r_kfoll <= i_next_byte;
        end else if (i_cmd.root_ld) begin
            r_kpred <= ROOT_PRED;
            r_kfoll <= '0;
        end else if (i_cmd.root_inc) begin
            r_kfoll <= r_root + 1'b1;
        end
        if (i_cmd.hash) begin
            r_sq <= {16'b0, w_hs} * {16'b0, w_hs};
        end
        if (i_cmd.set_home) begin
            r_cur <= w_home;
        end else if (i_cmd.walk) begin
            r_cur <= r_rd.next;
        end
        if (i_cmd.probe_start) begin
            r_tail     <= r_cur;
            r_tail_ent <= r_rd;
            r_cand     <= r_cur + PROBE_GAP;
        end else if (i_cmd.probe_next) begin
            r_cand <= r_cand + 1'b1;
        end
        if (i_cmd.finish) begin
            r_slot  <= '0;
            r_found <= 1'b0;
            r_full  <= 1'b0;
            case (i_cmd.res)
                RES_CUR: begin
                    r_slot  <= r_cur;
                    r_found <= 1'b1;
                end
                RES_CAND: begin
                    r_slot  <= r_cand;
                    r_found <= 1'b1;
                end
                RES_FULL: r_full <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_sts.in_func   = t_func'(i_func);
    assign o_sts.func      = r_func;
    assign o_sts.init_mode = (r_func == FUNC_INIT);
    assign o_sts.used      = r_rd.used;
    assign o_sts.match     = r_rd.used && (r_rd.pred == r_kpred) && (r_rd.foll == r_kfoll);
    assign o_sts.next_zero = (r_rd.next == '0);
    assign o_sts.step_last = (r_steps[SLOT_W-1:0] == SLOT_MASK);
    assign o_sts.tail_last = (r_steps == STEP_W'(TABLE_ENTRIES));
    assign o_sts.clr_last  = (r_clr == SLOT_MASK);
    assign o_sts.root_last = (r_root == ROOT_LAST);

    assign o_slot       = r_slot;
    assign o_found      = r_found;
    assign o_table_full = r_full;
    assign o_strobe     = r_strobe;

endmodule

// File: hdl/lste_checker.sv
// port-level checker of the lzw string table engine and its bind
`include "assert_macros.svh"

module lste_port_checker import lste_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_strobe,
    input logic [SLOT_W-1:0] o_slot,
    input logic              o_found,
    input logic              o_table_full
);

    // a result is never both a hit and a full table
    `AST_IMP(a_found_full_excl, i_clk, i_rst_n, o_strobe, !(o_found && o_table_full))
    // a miss or a full table reports slot zero
    `AST_IMP(a_miss_slot_zero, i_clk, i_rst_n, o_strobe && !o_found, o_slot == '0)
    // the engine goes idle at the edge that publishes a result
    `AST_IMP(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy)
    // a transfer either starts work or yields its result right away
    `AST_NXT(a_accept_moves, i_clk, i_rst_n, start && !busy, busy || o_strobe)

endmodule

bind lzw_string_table_engine lste_port_checker u_lste_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_slot       (o_slot),
    .o_found      (o_found),
    .o_table_full (o_table_full)
);
